// ----- rtl/tpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tpt_pkg: shared types and constants for the tlb page table translator
// sizes of the tlb, page table and counters, plus the request and response
// structs passed between the lookup units and the control logic
// ----------------------------------------------------------------------------
package tpt_pkg;

	localparam int TLB_DEPTH     = 16;
	localparam int TLB_IDX_W     = $clog2(TLB_DEPTH);
	localparam int COUNTER_WIDTH = 32;

	localparam int PAGE_W      = 8;
	localparam int OFFSET_W    = 8;
	localparam int FRAME_W     = 8;
	localparam int VADDR_W     = PAGE_W + OFFSET_W;
	localparam int PAGE_COUNT  = 1 << PAGE_W;
	localparam int FREE_W      = FRAME_W + 1;
	localparam int FRAME_LIMIT = 1 << FRAME_W;

	// fifo pointer starts on the last slot so the first fill lands in slot 0
	localparam logic [TLB_IDX_W-1:0] FIFO_PTR_RESET = TLB_IDX_W'(TLB_DEPTH - 1);

	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame;
	} tlb_lookup_t;

	typedef struct packed {
		logic               en;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} tlb_fill_t;

	typedef struct packed {
		logic              rd_en;
		logic [PAGE_W-1:0] rd_page;
		logic              fault_en;
		logic [PAGE_W-1:0] fault_page;
	} pt_req_t;

	typedef struct packed {
		logic               valid;
		logic [FRAME_W-1:0] frame;
		logic [FRAME_W-1:0] free_frame;
	} pt_resp_t;

endpackage

// ----- rtl/tpt_tlb.sv -----
// ----------------------------------------------------------------------------
// tpt_tlb: fully associative translation cache
// register-based entries searched in parallel, lowest matching slot wins,
// fills go round robin through a fifo pointer
// ----------------------------------------------------------------------------
module tpt_tlb (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tpt_pkg::PAGE_W-1:0] lookup_page,
	output tpt_pkg::tlb_lookup_t       lookup,
	input  tpt_pkg::tlb_fill_t         fill
);
	import tpt_pkg::*;

	logic [TLB_DEPTH-1:0]     valid_q;
	logic [PAGE_W-1:0]        page_q  [TLB_DEPTH];
	logic [FRAME_W-1:0]       frame_q [TLB_DEPTH];
	logic [TLB_IDX_W-1:0]     fifo_ptr_q;
	logic [TLB_IDX_W-1:0]     fill_idx;
	logic [TLB_DEPTH-1:0]     match;

	always_comb begin
		for (int i = 0; i < TLB_DEPTH; i++) begin
			match[i] = valid_q[i] && (page_q[i] == lookup_page);
		end
	end

	// priority select, lowest index overrides
	always_comb begin
		lookup.hit   = |match;
		lookup.frame = '0;
		for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				lookup.frame = frame_q[i];
			end
		end
	end

	assign fill_idx = (fifo_ptr_q == TLB_IDX_W'(TLB_DEPTH - 1)) ? '0 : fifo_ptr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			fifo_ptr_q <= FIFO_PTR_RESET;
		end else if (fill.en) begin
			valid_q[fill_idx] <= 1'b1;
			fifo_ptr_q        <= fill_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (fill.en) begin
			page_q[fill_idx]  <= fill.page;
			frame_q[fill_idx] <= fill.frame;
		end
	end

endmodule

// ----- rtl/tpt_page_table.sv -----
// ----------------------------------------------------------------------------
// tpt_page_table: page table memory with demand allocation
// synchronous frame memory, per-page valid flags and the free frame counter
// ----------------------------------------------------------------------------
module tpt_page_table (
	input  logic              clk,
	input  logic              arst_n,
	input  tpt_pkg::pt_req_t  req,
	output tpt_pkg::pt_resp_t resp
);
	import tpt_pkg::*;

	logic [FRAME_W-1:0]    frame_mem [PAGE_COUNT];
	logic [PAGE_COUNT-1:0] valid_q;
	logic [FRAME_W-1:0]    rd_frame_q;
	logic                  rd_valid_q;
	logic [FREE_W-1:0]     free_frame_q;

	// frame memory with a registered read
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_frame_q <= frame_mem[req.rd_page];
		end
		if (req.fault_en) begin
			frame_mem[req.fault_page] <= free_frame_q[FRAME_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			rd_valid_q   <= 1'b0;
			free_frame_q <= '0;
		end else begin
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_page];
			end
			if (req.fault_en) begin
				valid_q[req.fault_page] <= 1'b1;
				// saturate once every frame is handed out
				if (free_frame_q < FREE_W'(FRAME_LIMIT)) begin
					free_frame_q <= free_frame_q + 1'b1;
				end
			end
		end
	end

	assign resp.valid      = rd_valid_q;
	assign resp.frame      = rd_frame_q;
	assign resp.free_frame = free_frame_q[FRAME_W-1:0];

endmodule

// ----- rtl/tlb_page_table_translator.sv -----
// ----------------------------------------------------------------------------
// tlb_page_table_translator: virtual to physical address translation
// 16-entry tlb in front of a 256-entry page table with demand paging
// ----------------------------------------------------------------------------
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, virtual_address             | into block
//  out     | out_valid, out_stall, physical_address,         | out of block
//          | tlb_hit, page_fault, hit_total, fault_total     |
//
// on accept a transaction launches the page table memory read and enters
// the resolve state, which resolves tlb / page table / fault from the
// registered read data and loads the output register
// in_stall is high while an item is being resolved; a held output only
// delays resolution, the accepted item waits with its read data
// reset clears tlb valid flags, page valid flags, pointers and counters;
// no clearing pass is needed
//
module tlb_page_table_translator (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] virtual_address,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] physical_address,
	output logic        tlb_hit,
	output logic        page_fault,
	output logic [31:0] hit_total,
	output logic [31:0] fault_total
);
	import tpt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'b01,
		ST_RESOLVE = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	logic                     in_fire;
	logic                     resolve_fire;
	logic [VADDR_W-1:0]       va_s1;
	logic [PAGE_W-1:0]        page_s1;

	tlb_lookup_t              tlb_lookup;
	tlb_fill_t                tlb_fill;
	pt_req_t                  pt_req;
	pt_resp_t                 pt_resp;

	logic [FRAME_W-1:0]       frame;
	logic                     hit;
	logic                     fault;

	logic [COUNTER_WIDTH-1:0] hit_cnt_q;
	logic [COUNTER_WIDTH-1:0] fault_cnt_q;
	logic [COUNTER_WIDTH-1:0] hit_cnt_d;
	logic [COUNTER_WIDTH-1:0] fault_cnt_d;

	logic                     out_valid_q;
	logic [VADDR_W-1:0]       paddr_q;
	logic                     hit_q;
	logic                     fault_q;
	logic [31:0]              hit_total_q;
	logic [31:0]              fault_total_q;

	// handshakes
	assign in_stall     = (state_q == ST_RESOLVE);
	assign in_fire      = in_valid && !in_stall;
	// resolve only when the output slot is free or being emptied
	assign resolve_fire = (state_q == ST_RESOLVE) && (!out_valid_q || !out_stall);

	assign page_s1 = va_s1[VADDR_W-1:OFFSET_W];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_RESOLVE;
				end
			end
			ST_RESOLVE: begin
				if (resolve_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			va_s1 <= virtual_address;
		end
	end

	// page table read launched straight from the input port on accept
	assign pt_req.rd_en      = in_fire;
	assign pt_req.rd_page    = virtual_address[VADDR_W-1:OFFSET_W];
	assign pt_req.fault_en   = resolve_fire && fault;
	assign pt_req.fault_page = page_s1;

	tpt_page_table u_page_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pt_req),
		.resp   (pt_resp)
	);

	tpt_tlb u_tlb (
		.clk         (clk),
		.arst_n      (arst_n),
		.lookup_page (page_s1),
		.lookup      (tlb_lookup),
		.fill        (tlb_fill)
	);

	// resolve: tlb first, then page table, else allocate a fresh frame
	always_comb begin
		hit   = 1'b0;
		fault = 1'b0;
		priority if (tlb_lookup.hit) begin
			hit   = 1'b1;
			frame = tlb_lookup.frame;
		end else if (pt_resp.valid) begin
			frame = pt_resp.frame;
		end else begin
			fault = 1'b1;
			frame = pt_resp.free_frame;
		end
	end

	// page table hit refills the tlb; a fault leaves the tlb alone
	assign tlb_fill.en    = resolve_fire && !tlb_lookup.hit && pt_resp.valid;
	assign tlb_fill.page  = page_s1;
	assign tlb_fill.frame = pt_resp.frame;

	// wrapping counters
	assign hit_cnt_d   = hit   ? hit_cnt_q + 1'b1   : hit_cnt_q;
	assign fault_cnt_d = fault ? fault_cnt_q + 1'b1 : fault_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (resolve_fire) begin
				hit_cnt_q   <= hit_cnt_d;
				fault_cnt_q <= fault_cnt_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register, loaded only when the slot is free or being emptied
	always_ff @(posedge clk) begin
		if (resolve_fire) begin
			paddr_q       <= {frame, va_s1[OFFSET_W-1:0]};
			hit_q         <= hit;
			fault_q       <= fault;
			hit_total_q   <= 32'(hit_cnt_d);
			fault_total_q <= 32'(fault_cnt_d);
		end
	end

	assign out_valid        = out_valid_q;
	assign physical_address = paddr_q;
	assign tlb_hit          = hit_q;
	assign page_fault       = fault_q;
	assign hit_total        = hit_total_q;
	assign fault_total      = fault_total_q;

endmodule
